/* sv/itra_pkg.sv */
package itra_pkg;

    // Width of the signed input value
    localparam int VALUE_WIDTH = 32;

    // Radix field and its legal range
    localparam int RADIX_WIDTH   = 6;
    localparam int RADIX_MIN     = 2;
    localparam int RADIX_MAX     = 36;
    localparam int DECIMAL_RADIX = 10;

    // A digit value is below the radix, so it fits the radix width
    localparam int DIGIT_WIDTH = RADIX_WIDTH;
    localparam int CHAR_WIDTH  = 8;

    // Long division: quotient bits resolved per cycle, and cycles per digit
    localparam int STEP_BITS      = 8;
    localparam int DIV_CYCLES     = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int WORK_WIDTH     = DIV_CYCLES * STEP_BITS;
    localparam int STEP_CNT_WIDTH = $clog2(DIV_CYCLES + 1);

    // Digit stack: at most VALUE_WIDTH digits (binary)
    localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);
    localparam int ADDR_WIDTH  = $clog2(VALUE_WIDTH);

    // ASCII codes
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_PREP,
        ST_EMIT
    } itra_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic read_digit;
        logic pop_digit;
        logic sign_sel;
    } itra_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_last;
        logic quot_zero;
        logic show_sign;
        logic last_digit;
    } itra_status_t;

    // Map a digit value to '0'-'9' or 'A'-'Z'
    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] d_ext;
        d_ext = CHAR_WIDTH'(d);
        if (d_ext < CHAR_WIDTH'(DECIMAL_RADIX))
        begin
            return CHAR_ZERO + d_ext;
        end
        return CHAR_A + (d_ext - CHAR_WIDTH'(DECIMAL_RADIX));
    endfunction

endpackage

/* sv/itra_if.sv */
// Request word: value and radix
interface itra_req_if import itra_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] number;
    logic [RADIX_WIDTH-1:0]        radix;

    modport source (output valid, number, radix, input ready);
    modport sink   (input valid, number, radix, output ready);
endinterface

// Text word: one character and its end-of-text flag
interface itra_text_if import itra_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CHAR_WIDTH-1:0] character;
    logic                  final_char;

    modport source (output valid, character, final_char, input ready);
    modport sink   (input valid, character, final_char, output ready);
endinterface

/* sv/itra_ctrl.sv */
module itra_ctrl import itra_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  itra_status_t status,
    output itra_cmd_t    cmd
);

    itra_state_t state_reg;
    itra_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_last && status.quot_zero)
                begin
                    state_next = status.show_sign ? ST_SIGN : ST_PREP;
                end
            end
            ST_SIGN:
            begin
                if (out_ready)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    state_next = status.last_digit ? ST_IDLE : ST_PREP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_SIGN:
            begin
                out_valid    = 1'b1;
                cmd.sign_sel = 1'b1;
            end
            ST_PREP:
            begin
                cmd.read_digit = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid     = 1'b1;
                cmd.pop_digit = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // A new request is never taken while text is on offer
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("request taken while text word pending");

    // A digit word is only offered after its read from the digit stack
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ($past(state_reg) == ST_PREP || $past(state_reg) == ST_EMIT))
        else $error("digit offered without a stack read");

endmodule

/* sv/itra_dp.sv */
module itra_dp import itra_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  itra_cmd_t                     cmd,
    output itra_status_t                  status,
    input  logic signed [VALUE_WIDTH-1:0] number,
    input  logic [RADIX_WIDTH-1:0]        radix,
    output logic [CHAR_WIDTH-1:0]         character,
    output logic                          final_char
);

    logic [WORK_WIDTH-1:0]     work_reg;
    logic [DIGIT_WIDTH-1:0]    rem_reg;
    logic [RADIX_WIDTH-1:0]    radix_reg;
    logic                      sign_reg;
    logic [STEP_CNT_WIDTH-1:0] step_cnt_reg;
    logic [COUNT_WIDTH-1:0]    count_reg;
    logic [DIGIT_WIDTH-1:0]    rd_reg;
    logic [DIGIT_WIDTH-1:0]    digit_mem [VALUE_WIDTH];

    logic [VALUE_WIDTH-1:0]    num_u;
    logic [VALUE_WIDTH-1:0]    mag_load;
    logic [RADIX_WIDTH-1:0]    radix_sat;
    logic [WORK_WIDTH-1:0]     work_next;
    logic [DIGIT_WIDTH:0]      rem_next;
    logic [COUNT_WIDTH-1:0]    count_dec;
    logic [ADDR_WIDTH-1:0]     wr_addr;
    logic [ADDR_WIDTH-1:0]     rd_addr;

    // Magnitude of the input; the most negative value maps to 2^(W-1)
    assign num_u    = $unsigned(number);
    assign mag_load = num_u[VALUE_WIDTH-1] ? (~num_u + VALUE_WIDTH'(1)) : num_u;

    // Clamp the radix to 2..36
    always_comb
    begin
        radix_sat = radix;
        if (radix < RADIX_WIDTH'(RADIX_MIN))
        begin
            radix_sat = RADIX_WIDTH'(RADIX_MIN);
        end
        else if (radix > RADIX_WIDTH'(RADIX_MAX))
        begin
            radix_sat = RADIX_WIDTH'(RADIX_MAX);
        end
    end

    // Restoring division: shift numerator bits out the top, quotient bits in the bottom
    always_comb
    begin
        work_next = work_reg;
        rem_next  = {1'b0, rem_reg};
        for (int i = 0; i < STEP_BITS; i++)
        begin
            rem_next  = {rem_next[DIGIT_WIDTH-1:0], work_next[WORK_WIDTH-1]};
            work_next = {work_next[WORK_WIDTH-2:0], 1'b0};
            if (rem_next >= {1'b0, radix_reg})
            begin
                rem_next     = rem_next - {1'b0, radix_reg};
                work_next[0] = 1'b1;
            end
        end
    end

    assign count_dec = count_reg - COUNT_WIDTH'(1);
    assign wr_addr   = count_reg[ADDR_WIDTH-1:0];
    assign rd_addr   = count_dec[ADDR_WIDTH-1:0];

    assign status.div_last   = (step_cnt_reg == STEP_CNT_WIDTH'(DIV_CYCLES - 1));
    assign status.quot_zero  = (work_next == '0);
    assign status.show_sign  = sign_reg;
    assign status.last_digit = (count_reg == COUNT_WIDTH'(1));

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg <= '0;
            count_reg    <= '0;
        end
        else if (cmd.load)
        begin
            step_cnt_reg <= '0;
            count_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            if (status.div_last)
            begin
                step_cnt_reg <= '0;
                count_reg    <= count_reg + COUNT_WIDTH'(1);
            end
            else
            begin
                step_cnt_reg <= step_cnt_reg + STEP_CNT_WIDTH'(1);
            end
        end
        else if (cmd.pop_digit)
        begin
            count_reg <= count_dec;
        end
    end

    // Division registers; remainder restarts at zero for every digit
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg  <= WORK_WIDTH'(mag_load);
            rem_reg   <= '0;
            radix_reg <= radix_sat;
            sign_reg  <= num_u[VALUE_WIDTH-1] && (radix_sat == RADIX_WIDTH'(DECIMAL_RADIX));
        end
        else if (cmd.div_step)
        begin
            work_reg <= work_next;
            rem_reg  <= status.div_last ? '0 : rem_next[DIGIT_WIDTH-1:0];
        end
    end

    // Digit stack: push least significant digit first, read back from the top
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && status.div_last)
        begin
            digit_mem[wr_addr] <= rem_next[DIGIT_WIDTH-1:0];
        end
        if (cmd.read_digit)
        begin
            rd_reg <= digit_mem[rd_addr];
        end
    end

    // Text word payload
    assign character  = cmd.sign_sel ? CHAR_MINUS : digit_char(rd_reg);
    assign final_char = !cmd.sign_sel && status.last_digit;

    // The stack never overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && status.div_last) |-> (count_reg < COUNT_WIDTH'(VALUE_WIDTH)))
        else $error("digit stack overflow");

    // Reads and pops only happen with digits on the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.read_digit || cmd.pop_digit) |-> (count_reg != '0))
        else $error("digit stack underflow");

    // A read is followed by the offer of that digit
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_digit |=> (count_reg == $past(count_reg)) && !cmd.div_step)
        else $error("digit stack changed between read and offer");

endmodule

/* sv/integer_to_radix_ascii.sv */
// Converts a signed 32-bit value to ASCII text in radix 2 to 36 (radix values
// outside that range are clamped), most significant digit first, digits above
// nine as 'A'-'Z'. A '-' leads only for negative values in radix ten; zero
// gives "0". One character per text word, the last one flagged by final_char.
// Timing: one request at a time. Long division resolves 8 quotient bits per
// cycle over the 32-bit magnitude for each digit. Each digit character is then
// read through the registered digit stack before it is offered, and text.ready
// can stall any character.
module integer_to_radix_ascii import itra_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    itra_req_if.sink    request,
    itra_text_if.source text
);

    itra_cmd_t    cmd;
    itra_status_t status;

    itra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .status    (status),
        .cmd       (cmd)
    );

    itra_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .number     (request.number),
        .radix      (request.radix),
        .character  (text.character),
        .final_char (text.final_char)
    );

endmodule
